>>> src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the keyed slot store.
// Depends on nothing; each macro takes a label, clock, reset and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/kss_pkg.sv
// Package for the keyed slot store: field widths, status and op codes,
// default sizes and the search result struct. Depends on nothing.
package kss_pkg;

  localparam int KEY_W  = 32;
  localparam int SIZE_W = 7;
  localparam int IDX_W  = 6;
  localparam int OFF_W  = 11;
  localparam int WORD_W = 32;
  localparam int ST_W   = 2;
  localparam int CMP_W  = 18;
  localparam int IN_W   = 80;
  localparam int OUT_W  = 56;
  localparam int TBL_W  = KEY_W + OFF_W + SIZE_W;

  localparam int MAX_ENTRIES_DEF  = 32;
  localparam int BUFFER_WORDS_DEF = 1024;

  localparam logic [OFF_W-1:0] CAP_RESET = 11'd1024;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_NO_SPACE  = 2'd2;
  localparam logic [ST_W-1:0] ST_TOO_LARGE = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic done;
    logic found;
  } srch_res_t;

endpackage

>>> src/keyed_slot_store_bump_alloc.sv
// Top level of the keyed slot store with bump allocation of buffer words.
// Depends on kss_pkg, kss_ram, kss_search and assert_macros.svh.
//
// Requests arrive on the in_ stream: op, key, size, word index and data word.
// A write request finds or appends the keyed entry and stores one word of it;
// a read request returns the entry's size, offset and one stored word.
// Every request gives exactly one result on the out_ stream.
// The cfg_ channel writes the allocator capacity in words; it is always
// ready and must only be written while no request is in flight.
// The key search compares one stored key per cycle through the table memory,
// which has a registered read port, until a key matches or every stored key
// has been compared. A read that returns a word then passes through a buffer
// read state before its result is registered.
// in_tready is high only between requests.
// The result is held in an output register; a new request may be accepted
// while it waits, but that request does not finish until the held result
// is taken. Reset empties the table, clears the allocator and sets the
// capacity to 1024 words; buffer contents are not cleared.
`include "assert_macros.svh"

module keyed_slot_store_bump_alloc #(
  parameter int MAX_ENTRIES  = kss_pkg::MAX_ENTRIES_DEF,
  parameter int BUFFER_WORDS = kss_pkg::BUFFER_WORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // op[0], key[32:1], size_words[39:33], word_index[45:40], data_word[77:46]
  input  logic [kss_pkg::IN_W-1:0]   in_tdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // status[1:0], entry_size[8:2], entry_offset[19:9], read_word[51:20]
  output logic [kss_pkg::OUT_W-1:0]  out_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [kss_pkg::OFF_W-1:0]  cfg_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready
);

  import kss_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int BAW   = $clog2(BUFFER_WORDS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_BUFRD  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [OFF_W-1:0]  reserved_r, reserved_nxt;
  logic [OFF_W-1:0]  cap_r;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r;

  logic              op_r;
  logic [KEY_W-1:0]  key_r;
  logic [SIZE_W-1:0] size_r;
  logic [IDX_W-1:0]  widx_r;
  logic [WORD_W-1:0] data_r;
  logic              found_r;
  logic [SIZE_W-1:0] esz_r;
  logic [OFF_W-1:0]  eoff_r;
  logic [ST_W-1:0]   st_r, st_nxt;
  logic [SIZE_W-1:0] rsz_r, rsz_nxt;
  logic [OFF_W-1:0]  roff_r, roff_nxt;
  logic [WORD_W-1:0] rw_r;

  logic              accept;
  logic              out_load;
  srch_res_t         srch;
  logic              tbl_re;
  logic [AW-1:0]     tbl_raddr;
  logic [TBL_W-1:0]  tbl_rdata;
  logic              tbl_we;
  logic [TBL_W-1:0]  tbl_wdata;
  logic              buf_we;
  logic              buf_re;
  logic [WORD_W-1:0] buf_rdata;

  logic [SIZE_W-1:0] eff_sz;
  logic [OFF_W-1:0]  eff_off;
  logic [CMP_W-1:0]  pos;
  logic [CMP_W-1:0]  cap_use;
  logic [CMP_W-1:0]  bw_lim;
  logic              fits;
  logic              full;
  logic              pos_bad;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);

  assign eff_sz  = found_r ? esz_r : size_r;
  assign eff_off = found_r ? eoff_r : reserved_r;
  assign pos     = CMP_W'(eff_off) + CMP_W'(widx_r);
  assign bw_lim  = CMP_W'(BUFFER_WORDS);
  assign cap_use = (CMP_W'(cap_r) > bw_lim) ? bw_lim : CMP_W'(cap_r);
  assign fits    = (CMP_W'(reserved_r) + CMP_W'(size_r)) <= cap_use;
  assign full    = (count_r >= CNT_W'(MAX_ENTRIES));
  assign pos_bad = (pos >= bw_lim);

  assign tbl_wdata = {size_r, reserved_r, key_r};

  kss_search #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .CNT_W      (CNT_W),
    .AW         (AW)
  ) u_search (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .key    (key_r),
    .count  (count_r),
    .tbl_key(tbl_rdata[KEY_W-1:0]),
    .rd_en  (tbl_re),
    .raddr  (tbl_raddr),
    .res    (srch)
  );

  kss_ram #(
    .WIDTH(TBL_W),
    .DEPTH(MAX_ENTRIES),
    .AW   (AW)
  ) u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(count_r[AW-1:0]),
    .wdata(tbl_wdata),
    .re   (tbl_re),
    .raddr(tbl_raddr),
    .rdata(tbl_rdata)
  );

  kss_ram #(
    .WIDTH(WORD_W),
    .DEPTH(BUFFER_WORDS),
    .AW   (BAW)
  ) u_buffer (
    .clk  (clk),
    .we   (buf_we),
    .waddr(pos[BAW-1:0]),
    .wdata(data_r),
    .re   (buf_re),
    .raddr(pos[BAW-1:0]),
    .rdata(buf_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    reserved_nxt = reserved_r;
    st_nxt       = st_r;
    rsz_nxt      = rsz_r;
    roff_nxt     = roff_r;
    tbl_we       = 1'b0;
    buf_we       = 1'b0;
    buf_re       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (srch.done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        if (op_r == OP_READ) begin
          if (!found_r) begin
            st_nxt   = ST_NOT_FOUND;
            rsz_nxt  = '0;
            roff_nxt = '0;
          end else if ((SIZE_W'(widx_r) >= esz_r) || pos_bad) begin
            st_nxt   = ST_TOO_LARGE;
            rsz_nxt  = esz_r;
            roff_nxt = eoff_r;
          end else begin
            st_nxt    = ST_OK;
            rsz_nxt   = esz_r;
            roff_nxt  = eoff_r;
            buf_re    = 1'b1;
            state_nxt = S_BUFRD;
          end
        end else begin
          if (!found_r && (full || !fits)) begin
            st_nxt   = ST_NO_SPACE;
            rsz_nxt  = '0;
            roff_nxt = '0;
          end else begin
            if (!found_r) begin
              tbl_we       = 1'b1;
              count_nxt    = count_r + 1'b1;
              reserved_nxt = reserved_r + OFF_W'(size_r);
            end
            rsz_nxt  = eff_sz;
            roff_nxt = eff_off;
            if ((size_r > eff_sz) || (SIZE_W'(widx_r) >= size_r) || pos_bad) begin
              st_nxt = ST_TOO_LARGE;
            end else begin
              st_nxt = ST_OK;
              buf_we = 1'b1;
            end
          end
        end
      end
      S_BUFRD: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      reserved_r  <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      reserved_r  <= reserved_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_tdata[0];
      key_r  <= in_tdata[32:1];
      size_r <= in_tdata[39:33];
      widx_r <= in_tdata[45:40];
      data_r <= in_tdata[77:46];
    end
    if ((state_r == S_SEARCH) && srch.done) begin
      found_r <= srch.found;
      esz_r   <= tbl_rdata[TBL_W-1 -: SIZE_W];
      eoff_r  <= tbl_rdata[KEY_W +: OFF_W];
    end
    st_r   <= st_nxt;
    rsz_r  <= rsz_nxt;
    roff_r <= roff_nxt;
    if (state_r == S_DECIDE) begin
      rw_r <= '0;
    end else if (state_r == S_BUFRD) begin
      rw_r <= buf_rdata;
    end
    if (out_load) begin
      out_data_r <= {4'd0, rw_r, roff_r, rsz_r, st_r};
    end
  end

  `ASSERT_NEXT(a_accept_starts_search, clk, rst_n, accept, state_r == S_SEARCH,
    "accepted request did not start a search")
  `ASSERT_SAME(a_append_has_room, clk, rst_n, tbl_we, count_r < CNT_W'(MAX_ENTRIES),
    "entry appended to a full table")
  `ASSERT_SAME(a_buf_write_in_range, clk, rst_n, buf_we, pos < bw_lim,
    "buffer write outside the buffer")
  `ASSERT_NEXT(a_reserved_grows, clk, rst_n, 1'b1, reserved_r >= $past(reserved_r),
    "reserved word count decreased")

endmodule

>>> src/kss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module kss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/kss_search.sv
// Key search sequencer: steps through the entry table one slot a cycle and
// compares each stored key with the request key until one matches. Depends on kss_pkg.
module kss_search #(
  parameter int MAX_ENTRIES = kss_pkg::MAX_ENTRIES_DEF,
  parameter int CNT_W       = $clog2(MAX_ENTRIES + 1),
  parameter int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [kss_pkg::KEY_W-1:0] key,
  input  logic [CNT_W-1:0]        count,
  input  logic [kss_pkg::KEY_W-1:0] tbl_key,
  output logic                    rd_en,
  output logic [AW-1:0]           raddr,
  output kss_pkg::srch_res_t      res
);

  import kss_pkg::*;

  logic             busy_r, busy_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             match;
  logic             exhaust;

  assign match   = busy_r && pend_r && (tbl_key == key);
  assign exhaust = busy_r && !match && (idx_r >= count);
  assign rd_en   = busy_r && !match && !exhaust;
  assign raddr   = idx_r[AW-1:0];
  assign res.done  = match || exhaust;
  assign res.found = match;

  always_comb begin
    busy_nxt = busy_r;
    pend_nxt = pend_r;
    idx_nxt  = idx_r;
    if (start) begin
      busy_nxt = 1'b1;
      pend_nxt = 1'b0;
      idx_nxt  = '0;
    end else if (busy_r) begin
      if (match || exhaust) begin
        busy_nxt = 1'b0;
        pend_nxt = 1'b0;
      end else begin
        pend_nxt = 1'b1;
        idx_nxt  = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

>>> dv/kss_checker.sv
// Scoreboard for the keyed slot store: watches the request, result and capacity channels.
// It keeps its own copy of the key table, allocator and word buffer, and uses kss_pkg.
`timescale 1ns / 1ps

module kss_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [kss_pkg::IN_W-1:0]  in_tdata,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [kss_pkg::OUT_W-1:0] out_tdata,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [kss_pkg::OFF_W-1:0] cfg_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic                      drain_done,
  output int                        fail_count
);
  import kss_pkg::*;

  localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
  localparam int STORE_WORDS = BUFFER_WORDS_DEF;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
    logic [ST_W-1:0]   status;
  } store_result_t;

  logic [KEY_W-1:0]  slot_key [TABLE_DEPTH];
  int                slot_len [TABLE_DEPTH];
  int                slot_off [TABLE_DEPTH];
  int                slot_count;
  int                words_taken;
  int                cap_words;
  logic [WORD_W-1:0] store_mem [STORE_WORDS];
  store_result_t     expected_q[$];
  int                errors;
  logic              drain_checked;

  assign fail_count = errors;

  function automatic store_result_t predict_store(input logic [IN_W-1:0] req);
    logic              op;
    logic [KEY_W-1:0]  key;
    int                size;
    int                idx;
    int                slot;
    int                usable;
    int                pos;
    int                i;
    store_result_t     r;
    op = req[0];
    key = req[32:1];
    size = req[39:33];
    idx = req[45:40];
    r = '0;
    slot = -1;
    for (i = 0; i < slot_count; i++) begin
      if (slot < 0 && slot_key[i] == key) slot = i;
    end
    if (op == OP_READ) begin
      if (slot < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        r.size = SIZE_W'(slot_len[slot]);
        r.offset = OFF_W'(slot_off[slot]);
        pos = slot_off[slot] + idx;
        if (idx >= slot_len[slot] || pos >= STORE_WORDS) begin
          r.status = ST_TOO_LARGE;
        end else begin
          r.status = ST_OK;
          r.word = store_mem[pos];
        end
      end
    end else begin
      if (slot < 0) begin
        usable = (cap_words > STORE_WORDS) ? STORE_WORDS : cap_words;
        if (slot_count >= TABLE_DEPTH || words_taken + size > usable) begin
          r.status = ST_NO_SPACE;
        end else begin
          slot = slot_count;
          slot_key[slot] = key;
          slot_off[slot] = words_taken;
          slot_len[slot] = size;
          words_taken += size;
          slot_count++;
        end
      end
      if (slot >= 0) begin
        r.size = SIZE_W'(slot_len[slot]);
        r.offset = OFF_W'(slot_off[slot]);
        pos = slot_off[slot] + idx;
        if (size > slot_len[slot] || idx >= size || pos >= STORE_WORDS) begin
          r.status = ST_TOO_LARGE;
        end else begin
          r.status = ST_OK;
          store_mem[pos] = req[77:46];
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    drain_checked = 1'b0;
    slot_count = 0;
    words_taken = 0;
    cap_words = CAP_RESET;
  end

  always @(posedge clk) begin
    store_result_t exp_r;
    store_result_t act_r;
    if (!rst_n) begin
      slot_count = 0;
      words_taken = 0;
      cap_words = CAP_RESET;
      expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        act_r = out_tdata[51:0];
        if (expected_q.size() == 0) begin
          $display("%0t: result with no request waiting, actual %h", $time, act_r);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("status", exp_r.status, act_r.status);
          check_field("entry_size", exp_r.size, act_r.size);
          check_field("entry_offset", exp_r.offset, act_r.offset);
          check_field("read_word", exp_r.word, act_r.word);
        end
      end
      if (in_tvalid && in_tready) expected_q.push_back(predict_store(in_tdata));
      if (cfg_valid && cfg_ready) cap_words = cfg_data;
      if (drain_done && !drain_checked) begin
        drain_checked = 1'b1;
        while (expected_q.size() > 0) begin
          exp_r = expected_q.pop_front();
          $display("%0t: result never arrived, expected %h actual none", $time, exp_r);
          errors++;
        end
      end
    end
  end

endmodule

>>> dv/tb_top.sv
// Top of the keyed slot store testbench: clock, reset, request and capacity stimulus.
// Depends on kss_pkg, the keyed_slot_store_bump_alloc block and the kss_checker scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import kss_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int TABLE_DEPTH  = MAX_ENTRIES_DEF;
  localparam int STORE_WORDS  = BUFFER_WORDS_DEF;
  localparam int PHASE_REQS   = 150;
  localparam int HOLD_CYCLES  = 400;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OFF_W-1:0]  cfg_data = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              drain_done = 1'b0;
  int                fail_count;

  int                send_idle = 0;
  int                recv_idle = 0;
  logic              pressure_on = 1'b0;
  logic              hold_done = 1'b0;
  int                hold_left = 0;
  int                reqs_sent = 0;
  int                results_seen = 0;
  int                cycle_cnt = 0;

  logic [KEY_W-1:0]  ent_key [TABLE_DEPTH];
  int                ent_len [TABLE_DEPTH];
  int                ent_off [TABLE_DEPTH];
  int                ent_cnt = 0;
  int                words_used = 0;
  int                cap_now = CAP_RESET;
  bit                word_seen [STORE_WORDS];

  always #5 clk = ~clk;

  keyed_slot_store_bump_alloc i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
  );

  kss_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .drain_done(drain_done),
    .fail_count(fail_count)
  );

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (pressure_on && !hold_done) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) results_seen <= results_seen + 1;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("** keyed_slot_store_bump_alloc: FAILED **");
      $finish;
    end
  end

  function automatic int find_entry(input logic [KEY_W-1:0] key);
    int i;
    int slot;
    slot = -1;
    for (i = 0; i < ent_cnt; i++) begin
      if (slot < 0 && ent_key[i] == key) slot = i;
    end
    return slot;
  endfunction

  // Follows allocation and stored words so that reads never touch an unwritten word.
  function automatic void track_request(input logic op, input logic [KEY_W-1:0] key,
                                        input int size, input int idx);
    int slot;
    int usable;
    slot = find_entry(key);
    if (op == OP_WRITE) begin
      usable = (cap_now > STORE_WORDS) ? STORE_WORDS : cap_now;
      if (slot < 0 && ent_cnt < TABLE_DEPTH && words_used + size <= usable) begin
        slot = ent_cnt;
        ent_key[slot] = key;
        ent_len[slot] = size;
        ent_off[slot] = words_used;
        words_used += size;
        ent_cnt++;
      end
      if (slot >= 0 && size <= ent_len[slot] && idx < size) begin
        word_seen[ent_off[slot] + idx] = 1'b1;
      end
    end
  endfunction

  task automatic send_req(input logic [IN_W-1:0] req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= req;
    do @(posedge clk); while (!in_tready);
    reqs_sent++;
  endtask

  task automatic issue(input logic op, input logic [KEY_W-1:0] key, input int size,
                       input int idx, input logic [WORD_W-1:0] data);
    logic [SIZE_W-1:0] size_f;
    logic [IDX_W-1:0]  idx_f;
    size_f = SIZE_W'(size);
    idx_f = IDX_W'(idx);
    track_request(op, key, size, idx);
    send_req({2'b00, data, idx_f, size_f, key, op});
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_seen != reqs_sent) @(negedge clk);
  endtask

  task automatic write_capacity(input int value);
    wait_idle();
    cfg_data <= OFF_W'(value);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cap_now = value;
  endtask

  task automatic issue_random();
    int               r;
    int               s;
    int               pick;
    int               len;
    int               size;
    int               idx;
    int               i;
    logic [KEY_W-1:0] key;
    int               ok_idx[$];
    int               out_idx[$];
    r = $urandom_range(99);
    if (ent_cnt == 0 || r < 14) begin
      key = $urandom;
      s = $urandom_range(9);
      size = (s == 0) ? 0 : (s < 8) ? $urandom_range(8, 1) : $urandom_range(64, 9);
      idx = (size == 0 || $urandom_range(7) == 0) ? $urandom_range(63)
                                                 : $urandom_range(size - 1);
      issue(OP_WRITE, key, size, idx, $urandom);
    end else if (r < 18) begin
      key = $urandom;
      while (find_entry(key) >= 0) key = $urandom;
      issue(OP_READ, key, $urandom_range(64), $urandom_range(63), $urandom);
    end else if (r < 58) begin
      pick = $urandom_range(ent_cnt - 1);
      len = ent_len[pick];
      size = ($urandom_range(7) == 0) ? $urandom_range(64) : $urandom_range(len);
      idx = (size == 0 || $urandom_range(7) == 0) ? $urandom_range(63)
                                                 : $urandom_range(size - 1);
      issue(OP_WRITE, ent_key[pick], size, idx, $urandom);
    end else begin
      pick = $urandom_range(ent_cnt - 1);
      len = ent_len[pick];
      for (i = 0; i < 64; i++) begin
        if (i >= len) out_idx.push_back(i);
        else if (word_seen[ent_off[pick] + i]) ok_idx.push_back(i);
      end
      if (ok_idx.size() > 0 && (out_idx.size() == 0 || $urandom_range(4) != 0)) begin
        idx = ok_idx[$urandom_range(ok_idx.size() - 1)];
        issue(OP_READ, ent_key[pick], $urandom_range(64), idx, $urandom);
      end else if (out_idx.size() > 0) begin
        idx = out_idx[$urandom_range(out_idx.size() - 1)];
        issue(OP_READ, ent_key[pick], $urandom_range(64), idx, $urandom);
      end else begin
        issue(OP_WRITE, ent_key[pick], len, $urandom_range(len - 1), $urandom);
      end
    end
  endtask

  initial begin
    int ph;
    int n;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // With no capacity only zero-size entries can be appended.
    write_capacity(0);
    issue(OP_WRITE, 32'h0000_0000, 5, 0, 32'h1111_1111);
    issue(OP_WRITE, 32'h0000_0000, 0, 0, 32'h2222_2222);
    issue(OP_READ, 32'h0000_0000, 0, 0, 32'h0);
    issue(OP_READ, 32'hFFFF_FFFF, 64, 63, 32'hFFFF_FFFF);

    write_capacity(100);
    issue(OP_WRITE, 32'hFFFF_FFFF, 64, 63, 32'hFFFF_FFFF);
    issue(OP_WRITE, 32'hFFFF_FFFF, 64, 0, 32'h0000_0000);
    issue(OP_READ, 32'hFFFF_FFFF, 0, 63, 32'h0);
    issue(OP_READ, 32'hFFFF_FFFF, 0, 0, 32'h0);
    issue(OP_WRITE, 32'h5A5A_A5A5, 40, 0, 32'hDEAD_BEEF);
    issue(OP_WRITE, 32'h5A5A_A5A5, 36, 35, 32'h1234_5678);
    issue(OP_WRITE, 32'h0000_0001, 0, 0, 32'h0);
    issue(OP_WRITE, 32'h8000_0000, 1, 0, 32'h0);
    issue(OP_WRITE, 32'hFFFF_FFFF, 10, 10, 32'h5555_5555);
    issue(OP_WRITE, 32'hFFFF_FFFF, 10, 9, 32'hA5A5_A5A5);
    issue(OP_WRITE, 32'h5A5A_A5A5, 37, 0, 32'h0);
    issue(OP_READ, 32'h5A5A_A5A5, 0, 36, 32'h0);
    issue(OP_READ, 32'h5A5A_A5A5, 0, 35, 32'h0);
    issue(OP_READ, 32'hFFFF_FFFF, 0, 9, 32'h0);
    issue(OP_WRITE, 32'hFFFF_FFFF, 64, 62, $urandom);
    issue(OP_READ, 32'h8000_0000, 0, 0, 32'h0);

    for (ph = 0; ph < 5; ph++) begin
      unique case (ph)
        0: begin
          write_capacity(STORE_WORDS);
          send_idle = 0;
          recv_idle = 0;
        end
        1: begin
          write_capacity((words_used + 20 > STORE_WORDS) ? STORE_WORDS : words_used + 20);
          send_idle = 84;
          recv_idle = 0;
        end
        2: begin
          write_capacity((words_used > 10) ? words_used - 10 : 0);
          send_idle = 0;
          recv_idle = 84;
        end
        3: begin
          write_capacity(STORE_WORDS);
          send_idle = 14;
          recv_idle = 14;
        end
        default: begin
          write_capacity(700);
          send_idle = 0;
          recv_idle = 0;
          pressure_on = 1'b1;
        end
      endcase
      for (n = 0; n < PHASE_REQS; n++) issue_random();
    end

    wait_idle();
    repeat (40) @(negedge clk);
    drain_done <= 1'b1;
    @(negedge clk);
    if (fail_count == 0) begin
      $display("** keyed_slot_store_bump_alloc: PASSED **");
    end else begin
      $display("** keyed_slot_store_bump_alloc: FAILED **");
    end
    $finish;
  end

endmodule
